// ----- rtl/ieb_pkg.sv -----
// Shared types, codes and constants of the I2C EEPROM byte master.
package ieb_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned DevAddrW = 7;
  localparam int unsigned PhaseW   = 8;
  localparam int unsigned WaitW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitIdxW  = 4;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DevAddrW-1:0] DevAddrRst = 7'd80;
  localparam logic [PhaseW-1:0]   PhaseRst   = 8'd6;
  localparam logic [WaitW-1:0]    WaitRst    = 16'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDevAddr = 2'd0,
    CfgPhase   = 2'd1,
    CfgWait    = 2'd2
  } cfg_idx_e;

  typedef enum logic [ReqW-1:0] {
    ReqTick  = 2'd0,
    ReqWrite = 2'd1,
    ReqRead  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] mem_addr;
    logic [ByteW-1:0] write_data;
    logic             sda;
  } cmd_t;

  typedef struct packed {
    logic [DevAddrW-1:0] dev_addr;
    logic [PhaseW-1:0]   phase_ticks;
    logic [WaitW-1:0]    post_wait;
  } cfg_t;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] read_data;
    logic             nack;
  } res_t;

endpackage

// ----- rtl/ieb_front.sv -----
// Front end: classifies incoming words and holds them in a short command queue.
module ieb_front #(
  parameter int unsigned QueueDepth = ieb_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ieb_pkg::ReqW-1:0]   req_type_i,
  input  logic [ieb_pkg::ByteW-1:0]  mem_addr_i,
  input  logic [ieb_pkg::ByteW-1:0]  write_data_i,
  input  logic                       sda_in_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_pop_i,
  output ieb_pkg::cmd_t              cmd_o
);
  import ieb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_new;

  always_comb begin
    cmd_new.mem_addr   = mem_addr_i;
    cmd_new.write_data = write_data_i;
    cmd_new.sda        = sda_in_i;
    case (req_type_i)
      ReqTick:  cmd_new.op = OpTick;
      ReqWrite: cmd_new.op = OpWrite;
      ReqRead:  cmd_new.op = OpRead;
      default:  cmd_new.op = OpNone;
    endcase
  end

  assign in_stall_o  = (cnt_q == FullCnt);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ----- rtl/ieb_back.sv -----
// Back end: the bus sequencer that carries out one queued word per cycle while its output register is free or read.
module ieb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ieb_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  ieb_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ieb_pkg::res_t res_o
);
  import ieb_pkg::*;

  typedef enum logic [17:0] {
    StIdle   = 18'h00001,
    StStartA = 18'h00002,
    StStartB = 18'h00004,
    StRsA    = 18'h00008,
    StRsB    = 18'h00010,
    StTx0    = 18'h00020,
    StTx1    = 18'h00040,
    StTx2    = 18'h00080,
    StAck0   = 18'h00100,
    StAck1   = 18'h00200,
    StRxH    = 18'h00400,
    StRxL    = 18'h00800,
    StNaA    = 18'h01000,
    StNaB    = 18'h02000,
    StNaC    = 18'h04000,
    StStopA  = 18'h08000,
    StStopB  = 18'h10000,
    StWait   = 18'h20000
  } state_e;

  localparam logic [1:0] SlotDev  = 2'd0;
  localparam logic [1:0] SlotAddr = 2'd1;
  localparam logic [1:0] SlotLast = 2'd2;

  state_e             state_q, state_d;
  logic [1:0]         slot_q, slot_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   addr_q, addr_d;
  logic [ByteW-1:0]   data_q, data_d;
  logic               is_read_q, is_read_d;
  logic [WaitW-1:0]   wait_q, wait_d;
  logic               nack_q, nack_d;
  logic [ByteW-1:0]   rx_q, rx_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               done_q, done_d;
  logic               out_valid_q, out_valid_d;

  logic               fire;
  logic [PhaseW-1:0]  limit;
  logic [PhaseW-1:0]  phase_inc;
  logic [BitIdxW-1:0] bit_inc;
  logic [ByteW-1:0]   dev_wr;
  logic [ByteW-1:0]   dev_rd;

  assign fire      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = fire;
  assign limit     = (cfg_i.phase_ticks == '0) ? PhaseW'(1) : cfg_i.phase_ticks;
  assign phase_inc = phase_q + 1'b1;
  assign bit_inc   = bit_q + 1'b1;
  assign dev_wr    = {cfg_i.dev_addr, 1'b0};
  assign dev_rd    = {cfg_i.dev_addr, 1'b1};

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    addr_d      = addr_q;
    data_d      = data_q;
    is_read_d   = is_read_q;
    wait_d      = wait_q;
    nack_d      = nack_q;
    rx_d        = rx_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (fire) begin
      out_valid_d = 1'b1;
      done_d      = 1'b0;
      case (cmd_i.op)
        OpTick: begin
          if (state_q == StWait) begin
            if (wait_q >= cfg_i.post_wait) begin
              state_d = StIdle;
              done_d  = 1'b1;
            end else begin
              wait_d = wait_q + 1'b1;
            end
          end else if (state_q != StIdle) begin
            if (phase_inc >= limit) begin
              phase_d = '0;
              case (state_q)
                StStartA: begin
                  sda_d   = 1'b0;
                  state_d = StStartB;
                end
                StRsA: begin
                  sda_d   = 1'b0;
                  state_d = StRsB;
                end
                StStartB: begin
                  shift_d = dev_wr;
                  bit_d   = '0;
                  scl_d   = 1'b0;
                  slot_d  = SlotDev;
                  state_d = StTx0;
                end
                StRsB: begin
                  shift_d = dev_rd;
                  bit_d   = '0;
                  scl_d   = 1'b0;
                  slot_d  = SlotLast;
                  state_d = StTx0;
                end
                StTx0: begin
                  sda_d   = shift_q[ByteW-1];
                  state_d = StTx1;
                end
                StTx1: begin
                  scl_d   = 1'b1;
                  shift_d = {shift_q[ByteW-2:0], 1'b0};
                  state_d = StTx2;
                end
                StTx2: begin
                  bit_d = bit_inc;
                  if (!bit_inc[BitIdxW-1]) begin
                    scl_d   = 1'b0;
                    state_d = StTx0;
                  end else begin
                    scl_d   = 1'b1;
                    sda_d   = 1'b1;
                    state_d = StAck0;
                  end
                end
                StAck0: begin
                  if (cmd_i.sda) begin
                    nack_d = 1'b1;
                  end
                  scl_d   = 1'b0;
                  state_d = StAck1;
                end
                StAck1: begin
                  if (slot_q == SlotDev) begin
                    shift_d = addr_q;
                    bit_d   = '0;
                    scl_d   = 1'b0;
                    slot_d  = SlotAddr;
                    state_d = StTx0;
                  end else if (slot_q == SlotAddr) begin
                    if (is_read_q) begin
                      scl_d   = 1'b1;
                      sda_d   = 1'b1;
                      state_d = StRsA;
                    end else begin
                      shift_d = data_q;
                      bit_d   = '0;
                      scl_d   = 1'b0;
                      slot_d  = SlotLast;
                      state_d = StTx0;
                    end
                  end else if (is_read_q) begin
                    scl_d   = 1'b1;
                    sda_d   = 1'b1;
                    bit_d   = '0;
                    state_d = StRxH;
                  end else begin
                    sda_d   = 1'b0;
                    scl_d   = 1'b1;
                    state_d = StStopA;
                  end
                end
                StRxH: begin
                  rx_d    = {rx_q[ByteW-2:0], cmd_i.sda};
                  scl_d   = 1'b0;
                  state_d = StRxL;
                end
                StRxL: begin
                  bit_d = bit_inc;
                  if (!bit_inc[BitIdxW-1]) begin
                    scl_d   = 1'b1;
                    state_d = StRxH;
                  end else begin
                    scl_d   = 1'b0;
                    sda_d   = 1'b1;
                    state_d = StNaA;
                  end
                end
                StNaA: begin
                  scl_d   = 1'b1;
                  state_d = StNaB;
                end
                StNaB: begin
                  scl_d   = 1'b0;
                  sda_d   = 1'b1;
                  state_d = StNaC;
                end
                StNaC: begin
                  sda_d   = 1'b0;
                  scl_d   = 1'b1;
                  state_d = StStopA;
                end
                StStopA: begin
                  sda_d   = 1'b1;
                  state_d = StStopB;
                end
                StStopB: begin
                  wait_d  = '0;
                  state_d = StWait;
                end
                default: begin
                  state_d = StIdle;
                end
              endcase
            end else begin
              phase_d = phase_inc;
            end
          end
        end
        OpWrite, OpRead: begin
          if (state_q == StIdle) begin
            addr_d    = cmd_i.mem_addr;
            data_d    = cmd_i.write_data;
            is_read_d = (cmd_i.op == OpRead);
            nack_d    = 1'b0;
            phase_d   = '0;
            bit_d     = '0;
            scl_d     = 1'b1;
            sda_d     = 1'b1;
            state_d   = StStartA;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= SlotDev;
      phase_q     <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      addr_q      <= '0;
      data_q      <= '0;
      is_read_q   <= 1'b0;
      wait_q      <= '0;
      nack_q      <= 1'b0;
      rx_q        <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      addr_q      <= addr_d;
      data_q      <= data_d;
      is_read_q   <= is_read_d;
      wait_q      <= wait_d;
      nack_q      <= nack_d;
      rx_q        <= rx_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign res_o.scl       = scl_q;
  assign res_o.sda       = sda_q;
  assign res_o.busy      = (state_q != StIdle);
  assign res_o.done      = done_q;
  assign res_o.read_data = rx_q;
  assign res_o.nack      = nack_q;

endmodule

// ----- rtl/i2c_eeprom_byte_master.sv -----
// Top level of the I2C EEPROM byte master: configuration registers, front end and sequencer.
// Every input word yields one result word; one word is taken per clock cycle when not stalled.
// A word taken into an empty queue passes through its queue entry and the sequencer's output register to the outputs.
// The sequencer retires one queued word per cycle while its output register is free or read.
// Reset clears the queue, puts the sequencer in idle with both lines released and loads
// the configuration reset values.
module i2c_eeprom_byte_master #(
  parameter int unsigned QueueDepth = ieb_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ieb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ieb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ieb_pkg::ReqW-1:0]     req_type_i,
  input  logic [ieb_pkg::ByteW-1:0]    mem_addr_i,
  input  logic [ieb_pkg::ByteW-1:0]    write_data_i,
  input  logic                         sda_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         scl_level_o,
  output logic                         sda_drive_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic [ieb_pkg::ByteW-1:0]    read_data_o,
  output logic                         nack_seen_o
);
  import ieb_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic cmd_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDevAddr: cfg_d.dev_addr    = cfg_wdata_i[DevAddrW-1:0];
        CfgPhase:   cfg_d.phase_ticks = cfg_wdata_i[PhaseW-1:0];
        CfgWait:    cfg_d.post_wait   = cfg_wdata_i[WaitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= DevAddrRst;
      cfg_q.phase_ticks <= PhaseRst;
      cfg_q.post_wait   <= WaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ieb_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .mem_addr_i  (mem_addr_i),
    .write_data_i(write_data_i),
    .sda_in_i    (sda_in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  ieb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign scl_level_o = res.scl;
  assign sda_drive_o = res.sda;
  assign busy_res_o  = res.busy;
  assign done_res_o  = res.done;
  assign read_data_o = res.read_data;
  assign nack_seen_o = res.nack;

endmodule

// ----- tb/ieb_checker.sv -----
// Checker for the I2C EEPROM byte master: predicts each result word and compares it field by field.
module ieb_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ieb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ieb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [ieb_pkg::ReqW-1:0]     req_type_i,
  input  logic [ieb_pkg::ByteW-1:0]    mem_addr_i,
  input  logic [ieb_pkg::ByteW-1:0]    write_data_i,
  input  logic                         sda_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         scl_level_i,
  input  logic                         sda_drive_i,
  input  logic                         busy_res_i,
  input  logic                         done_res_i,
  input  logic [ieb_pkg::ByteW-1:0]    read_data_i,
  input  logic                         nack_seen_i,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o,
  output int unsigned                  completions_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ieb_pkg::*;

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StStartA  = 5'd1;
  localparam logic [4:0] StStartB  = 5'd2;
  localparam logic [4:0] StRsA     = 5'd3;
  localparam logic [4:0] StRsB     = 5'd4;
  localparam logic [4:0] StTxBase  = 5'd5;
  localparam logic [4:0] StAckBase = 5'd14;
  localparam logic [4:0] StRxH     = 5'd20;
  localparam logic [4:0] StRxL     = 5'd21;
  localparam logic [4:0] StNaA     = 5'd22;
  localparam logic [4:0] StNaB     = 5'd23;
  localparam logic [4:0] StNaC     = 5'd24;
  localparam logic [4:0] StStopA   = 5'd25;
  localparam logic [4:0] StStopB   = 5'd26;
  localparam logic [4:0] StWait    = 5'd27;
  localparam int unsigned MaxReports = 200;

  logic [DevAddrW-1:0] dev_addr;
  logic [PhaseW-1:0]   phase_len;
  logic [WaitW-1:0]    post_wait;

  logic [4:0]          seq_step;
  logic [PhaseW-1:0]   phase_cnt;
  logic [BitIdxW-1:0]  bit_cnt;
  logic [ByteW-1:0]    tx_shift;
  logic [ByteW-1:0]    addr_lat;
  logic [ByteW-1:0]    data_lat;
  logic                read_op;
  logic [WaitW-1:0]    settle_cnt;
  logic                nack_q;
  logic [ByteW-1:0]    rx_byte;
  logic                scl_q;
  logic                sda_q;

  res_t        expected_q[$];
  int unsigned errors;
  int unsigned outstanding;
  int unsigned completions;

  assign errors_o      = errors;
  assign pending_o     = outstanding;
  assign completions_o = completions;

  task automatic start_byte(input int unsigned slot, input logic [ByteW-1:0] value);
    tx_shift = value;
    bit_cnt  = '0;
    scl_q    = 1'b0;
    seq_step = StTxBase + 5'(3 * slot);
  endtask

  task automatic start_stop();
    sda_q    = 1'b0;
    scl_q    = 1'b1;
    seq_step = StStopA;
  endtask

  task automatic close_phase(input logic sda);
    int unsigned slot;
    int unsigned sub;
    slot = 0;
    sub  = 0;
    if (seq_step == StStartA || seq_step == StRsA) begin
      sda_q    = 1'b0;
      seq_step = seq_step + 5'd1;
    end else if (seq_step == StStartB) begin
      start_byte(0, {dev_addr, 1'b0});
    end else if (seq_step == StRsB) begin
      start_byte(2, {dev_addr, 1'b1});
    end else if (seq_step >= StTxBase && seq_step < StAckBase) begin
      slot = (seq_step - StTxBase) / 3;
      sub  = (seq_step - StTxBase) % 3;
      if (sub == 0) begin
        sda_q    = tx_shift[ByteW-1];
        seq_step = seq_step + 5'd1;
      end else if (sub == 1) begin
        scl_q    = 1'b1;
        tx_shift = tx_shift << 1;
        seq_step = seq_step + 5'd1;
      end else begin
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt < 8) begin
          scl_q    = 1'b0;
          seq_step = seq_step - 5'd2;
        end else begin
          scl_q    = 1'b1;
          sda_q    = 1'b1;
          seq_step = StAckBase + 5'(2 * slot);
        end
      end
    end else if (seq_step >= StAckBase && seq_step < StRxH) begin
      slot = (seq_step - StAckBase) / 2;
      sub  = (seq_step - StAckBase) % 2;
      if (sub == 0) begin
        if (sda) begin
          nack_q = 1'b1;
        end
        scl_q    = 1'b0;
        seq_step = seq_step + 5'd1;
      end else if (slot == 0) begin
        start_byte(1, addr_lat);
      end else if (slot == 1) begin
        if (read_op) begin
          scl_q    = 1'b1;
          sda_q    = 1'b1;
          seq_step = StRsA;
        end else begin
          start_byte(2, data_lat);
        end
      end else if (read_op) begin
        scl_q    = 1'b1;
        sda_q    = 1'b1;
        bit_cnt  = '0;
        seq_step = StRxH;
      end else begin
        start_stop();
      end
    end else if (seq_step == StRxH) begin
      rx_byte  = {rx_byte[ByteW-2:0], sda};
      scl_q    = 1'b0;
      seq_step = StRxL;
    end else if (seq_step == StRxL) begin
      bit_cnt = bit_cnt + 1'b1;
      if (bit_cnt < 8) begin
        scl_q    = 1'b1;
        seq_step = StRxH;
      end else begin
        scl_q    = 1'b0;
        sda_q    = 1'b1;
        seq_step = StNaA;
      end
    end else if (seq_step == StNaA) begin
      scl_q    = 1'b1;
      seq_step = StNaB;
    end else if (seq_step == StNaB) begin
      scl_q    = 1'b0;
      sda_q    = 1'b1;
      seq_step = StNaC;
    end else if (seq_step == StNaC) begin
      start_stop();
    end else if (seq_step == StStopA) begin
      sda_q    = 1'b1;
      seq_step = StStopB;
    end else if (seq_step == StStopB) begin
      settle_cnt = '0;
      seq_step   = StWait;
    end else begin
      seq_step = StIdle;
    end
  endtask

  task automatic advance_tick(input logic sda, output logic fin);
    logic [PhaseW-1:0] limit;
    limit = (phase_len == '0) ? PhaseW'(1) : phase_len;
    fin   = 1'b0;
    if (seq_step == StWait) begin
      if (settle_cnt >= post_wait) begin
        seq_step = StIdle;
        fin      = 1'b1;
      end else begin
        settle_cnt = settle_cnt + 1'b1;
      end
    end else if (seq_step == StIdle || seq_step > StWait) begin
      seq_step = StIdle;
    end else begin
      phase_cnt = phase_cnt + 1'b1;
      if (phase_cnt >= limit) begin
        phase_cnt = '0;
        close_phase(sda);
      end
    end
  endtask

  task automatic predict_lines(input cmd_t cmd, output res_t res);
    logic fin;
    fin = 1'b0;
    if (cmd.op == OpTick) begin
      advance_tick(cmd.sda, fin);
    end else if ((cmd.op == OpWrite || cmd.op == OpRead) &&
                 (seq_step == StIdle || seq_step > StWait)) begin
      addr_lat  = cmd.mem_addr;
      data_lat  = cmd.write_data;
      read_op   = (cmd.op == OpRead);
      nack_q    = 1'b0;
      phase_cnt = '0;
      bit_cnt   = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      seq_step  = StStartA;
    end
    res.scl       = scl_q;
    res.sda       = sda_q;
    res.busy      = (seq_step != StIdle && seq_step <= StWait);
    res.done      = fin;
    res.read_data = rx_byte;
    res.nack      = nack_q;
  endtask

  task automatic check_field(input string what, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t ns: %s expected %0h, got %0h", $time, what, want, seen);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    cmd_t cmd;
    res_t want;
    res_t seen;
    if (!rst_ni) begin
      dev_addr    = DevAddrRst;
      phase_len   = PhaseRst;
      post_wait   = WaitRst;
      seq_step    = StIdle;
      phase_cnt   = '0;
      bit_cnt     = '0;
      tx_shift    = '0;
      addr_lat    = '0;
      data_lat    = '0;
      read_op     = 1'b0;
      settle_cnt  = '0;
      nack_q      = 1'b0;
      rx_byte     = '0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      outstanding = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDevAddr: dev_addr  = cfg_wdata_i[DevAddrW-1:0];
          CfgPhase:   phase_len = cfg_wdata_i[PhaseW-1:0];
          CfgWait:    post_wait = cfg_wdata_i[WaitW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen = '{scl: scl_level_i, sda: sda_drive_i, busy: busy_res_i, done: done_res_i,
                 read_data: read_data_i, nack: nack_seen_i};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t ns: result word with no expectation waiting, got %0h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          outstanding--;
          check_field("scl_level", ByteW'(want.scl), ByteW'(seen.scl));
          check_field("sda_drive", ByteW'(want.sda), ByteW'(seen.sda));
          check_field("busy_res", ByteW'(want.busy), ByteW'(seen.busy));
          check_field("done_res", ByteW'(want.done), ByteW'(seen.done));
          check_field("read_data", want.read_data, seen.read_data);
          check_field("nack_seen", ByteW'(want.nack), ByteW'(seen.nack));
          if (want.done) begin
            completions++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cmd.op         = op_e'(req_type_i);
        cmd.mem_addr   = mem_addr_i;
        cmd.write_data = write_data_i;
        cmd.sda        = sda_in_i;
        predict_lines(cmd, want);
        expected_q.push_back(want);
        outstanding++;
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Top of the I2C EEPROM byte master testbench: clock, reset, stimulus, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ieb_pkg::*;

  localparam int unsigned WritePhases = 82;
  localparam int unsigned ReadPhases  = 103;
  localparam int unsigned IdlePct     = 12;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned Limit       = 4000;
  localparam int unsigned SettleWait  = 20;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = CfgDevAddr;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic [ReqW-1:0]     req_type_i   = OpTick;
  logic [ByteW-1:0]    mem_addr_i   = '0;
  logic [ByteW-1:0]    write_data_i = '0;
  logic                sda_in_i     = 1'b1;
  logic                out_stall_i  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                scl_level_o;
  logic                sda_drive_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [ByteW-1:0]    read_data_o;
  logic                nack_seen_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned completions;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cur_phase = PhaseRst;
  int unsigned cur_wait = WaitRst;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  bit          sda_forced = 1'b0;
  logic        sda_value = 1'b0;

  always #5ns clk_i = ~clk_i;

  i2c_eeprom_byte_master dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .req_type_i, .mem_addr_i, .write_data_i, .sda_in_i,
    .out_valid_o, .out_stall_i, .scl_level_o, .sda_drive_o, .busy_res_o, .done_res_o,
    .read_data_o, .nack_seen_o
  );

  ieb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .mem_addr_i, .write_data_i,
    .sda_in_i, .out_valid_i(out_valid_o), .out_stall_i, .scl_level_i(scl_level_o),
    .sda_drive_i(sda_drive_o), .busy_res_i(busy_res_o), .done_res_i(done_res_o),
    .read_data_i(read_data_o), .nack_seen_i(nack_seen_o),
    .errors_o(errors), .pending_o(pending), .completions_o(completions)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= Limit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // The one long hold-off lets the block fill up and stall its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  task automatic send_word(input op_e op, input logic [ByteW-1:0] addr,
                           input logic [ByteW-1:0] data, input logic sda);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= op;
    mem_addr_i   <= addr;
    write_data_i <= data;
    sda_in_i     <= sda;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_ticks(input int unsigned count, input int unsigned noise_pct);
    repeat (count) begin
      if ($urandom_range(99) < noise_pct) begin
        send_word(op_e'($urandom_range(OpWrite, OpNone)), ByteW'($urandom),
                  ByteW'($urandom), 1'($urandom));
      end
      send_word(OpTick, ByteW'($urandom), ByteW'($urandom),
                sda_forced ? sda_value : 1'($urandom));
    end
  endtask

  function automatic int unsigned transfer_ticks(input bit rd);
    return (rd ? ReadPhases : WritePhases) * (cur_phase == 0 ? 1 : cur_phase) + cur_wait + 1;
  endfunction

  task automatic run_transfer(input bit rd, input int unsigned cut, input int unsigned noise_pct);
    send_word(rd ? OpRead : OpWrite, ByteW'($urandom), ByteW'($urandom), 1'($urandom));
    send_ticks(transfer_ticks(rd) - cut, noise_pct);
  endtask

  task automatic load_setup(input logic [DevAddrW-1:0] dev, input logic [PhaseW-1:0] ph,
                            input logic [WaitW-1:0] pw);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgDevAddr;
    cfg_wdata_i <= CfgDataW'(dev);
    @(negedge clk_i);
    cfg_idx_i   <= CfgPhase;
    cfg_wdata_i <= CfgDataW'(ph);
    @(negedge clk_i);
    cfg_idx_i   <= CfgWait;
    cfg_wdata_i <= pw;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_phase = ph;
    cur_wait  = pw;
  endtask

  // A cut transfer leaves the block busy, so the next request is ignored and its
  // ticks finish the old transfer; no noise is sent then, and the last one is never cut.
  task automatic random_traffic(input int unsigned budget);
    int unsigned first;
    int unsigned cut;
    bit          rd;
    bit          last;
    bit          prev_cut;
    first    = words_sent;
    last     = 1'b0;
    prev_cut = 1'b0;
    while (!last) begin
      last = (words_sent - first) >= budget;
      if ($urandom_range(99) < 8) begin
        send_word($urandom_range(1) ? OpNone : OpTick, ByteW'($urandom), ByteW'($urandom),
                  1'($urandom));
      end
      rd  = 1'($urandom);
      cut = 0;
      if (!last && !prev_cut && $urandom_range(99) < 10) begin
        cut = $urandom_range(transfer_ticks(rd) / 4, 1);
      end
      run_transfer(rd, cut, prev_cut ? 0 : 3);
      prev_cut = (cut != 0);
    end
  endtask

  initial begin
    logic [DevAddrW-1:0] dev_pick;
    dev_pick = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(OpTick, 8'h00, 8'hFF, 1'b0);
    send_word(OpTick, 8'hFF, 8'h00, 1'b1);
    send_word(OpNone, 8'hFF, 8'hFF, 1'b1);
    sda_forced = 1'b1;
    sda_value  = 1'b0;
    send_word(OpWrite, 8'hFF, 8'h00, 1'b0);
    send_word(OpRead, 8'h00, 8'hFF, 1'b1);
    send_word(OpNone, 8'hAA, 8'h55, 1'b0);
    send_ticks(transfer_ticks(1'b0), 0);

    load_setup(7'd0, 8'd0, 16'd0);
    sda_value = 1'b1;
    send_word(OpRead, 8'h00, 8'hFF, 1'b0);
    send_ticks(transfer_ticks(1'b1), 0);
    sda_forced = 1'b0;

    load_setup(7'd127, 8'd1, 16'd0);
    random_traffic(100);

    load_setup(DevAddrW'($urandom), 8'd2, WaitW'($urandom_range(40)));
    calm    = 1'b1;
    hold_go = 1'b1;
    random_traffic(0);
    calm = 1'b0;

    dev_pick = DevAddrW'($urandom);
    load_setup(dev_pick, 8'd1, 16'hFFFF);
    send_word(OpRead, 8'h80, 8'h7F, 1'b1);
    send_ticks(ReadPhases + 20, 0);
    load_setup(dev_pick, 8'd1, 16'd3);
    send_ticks(2, 0);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);

    $display("Sent %0d words; %0d transfers completed across six register settings.",
             words_sent, completions);
    $display("Phase lengths 0, 1, 2 and 6, stop waits 0 to 65535 and a long output hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
